// ===== rtl/pbb_pkg.sv =====
`timescale 1ns / 1ps

package pbb_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned RadW    = 31;
  localparam int unsigned StepW   = 24;
  localparam int unsigned FracW   = 16;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned ProdW   = DataW + StepW + 1;
  localparam int unsigned ScaledW = ProdW - FracW;
  localparam int unsigned WideW   = ScaledW + 1;

  typedef logic signed [DataW-1:0]   q_t;
  typedef logic signed [ScaledW-1:0] scaled_t;
  typedef logic signed [WideW-1:0]   wide_t;

  localparam q_t QMax = {1'b0, {(DataW-1){1'b1}}};
  localparam q_t QMin = {1'b1, {(DataW-1){1'b0}}};

  localparam q_t WallLowReset  = -32'sd655360;
  localparam q_t WallHighReset = 32'sd655360;
  localparam q_t GravityReset  = '0;

  typedef enum logic [IdxW-1:0] {
    RegWallLowX  = 3'd0,
    RegWallHighX = 3'd1,
    RegWallLowY  = 3'd2,
    RegWallHighY = 3'd3,
    RegGravityX  = 3'd4,
    RegGravityY  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    q_t low_x;
    q_t high_x;
    q_t low_y;
    q_t high_y;
    q_t grav_x;
    q_t grav_y;
  } cfg_t;

  typedef struct packed {
    q_t              pos_x;
    q_t              pos_y;
    q_t              vel_x;
    q_t              vel_y;
    logic [RadW-1:0]  radius;
    logic [StepW-1:0] step;
  } ball_t;

  typedef struct packed {
    q_t      pos_x;
    q_t      pos_y;
    q_t      vel_x;
    q_t      vel_y;
    scaled_t dpos_x;
    scaled_t dpos_y;
    scaled_t dvel_x;
    scaled_t dvel_y;
  } delta_t;

  typedef struct packed {
    q_t new_pos_x;
    q_t new_pos_y;
    q_t new_vel_x;
    q_t new_vel_y;
  } result_t;

  function automatic q_t sat_q(input wide_t v);
    q_t res;
    if (v[WideW-1:DataW-1] == {(WideW-DataW+1){v[WideW-1]}}) begin
      res = q_t'(v[DataW-1:0]);
    end else begin
      res = v[WideW-1] ? QMin : QMax;
    end
    return res;
  endfunction

  function automatic q_t neg_q(input q_t v);
    q_t res;
    if (v == QMin) begin
      res = QMax;
    end else begin
      res = -v;
    end
    return res;
  endfunction

endpackage

// ===== rtl/pbb_wall_stage.sv =====
`timescale 1ns / 1ps

module pbb_wall_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          check_high_i,
  input  pbb_pkg::q_t   wall_x_i,
  input  pbb_pkg::q_t   wall_y_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  pbb_pkg::ball_t ball_i,
  output logic          valid_o,
  input  logic          ready_i,
  output pbb_pkg::ball_t ball_o
);

  typedef struct packed {
    pbb_pkg::q_t pos;
    pbb_pkg::q_t vel;
  } axis_t;

  logic           valid_q;
  pbb_pkg::ball_t ball_d, ball_q;
  axis_t          ax_x, ax_y;

  function automatic axis_t check_axis(input pbb_pkg::q_t pos, input pbb_pkg::q_t vel,
                                       input logic [pbb_pkg::RadW-1:0] r,
                                       input pbb_pkg::q_t wall, input logic high);
    axis_t          res;
    pbb_pkg::wide_t pos_w;
    pbb_pkg::wide_t r_w;
    pbb_pkg::wide_t wall_w;
    pos_w   = pbb_pkg::wide_t'(pos);
    r_w     = $signed({{(pbb_pkg::WideW-pbb_pkg::RadW){1'b0}}, r});
    wall_w  = pbb_pkg::wide_t'(wall);
    res.pos = pos;
    res.vel = vel;
    if (!high) begin
      if (pos_w - r_w < wall_w) begin
        res.pos = pbb_pkg::sat_q(wall_w + r_w);
        if (vel < 0) begin
          res.vel = pbb_pkg::neg_q(vel);
        end
      end
    end else begin
      if (pos_w + r_w > wall_w) begin
        res.pos = pbb_pkg::sat_q(wall_w - r_w);
        if (vel > 0) begin
          res.vel = pbb_pkg::neg_q(vel);
        end
      end
    end
    return res;
  endfunction

  always_comb begin
    ax_x = check_axis(ball_i.pos_x, ball_i.vel_x, ball_i.radius, wall_x_i, check_high_i);
    ax_y = check_axis(ball_i.pos_y, ball_i.vel_y, ball_i.radius, wall_y_i, check_high_i);
    ball_d       = ball_i;
    ball_d.pos_x = ax_x.pos;
    ball_d.vel_x = ax_x.vel;
    ball_d.pos_y = ax_y.pos;
    ball_d.vel_y = ax_y.vel;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ball_q <= ball_d;
    end
  end

  assign valid_o = valid_q;
  assign ball_o  = ball_q;

endmodule

// ===== rtl/pbb_mul_stage.sv =====
`timescale 1ns / 1ps

module pbb_mul_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pbb_pkg::q_t     grav_x_i,
  input  pbb_pkg::q_t     grav_y_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  pbb_pkg::ball_t  ball_i,
  output logic            valid_o,
  input  logic            ready_i,
  output pbb_pkg::delta_t delta_o
);

  logic                           valid_q;
  pbb_pkg::delta_t                delta_d, delta_q;
  logic signed [pbb_pkg::StepW:0] step_s;
  logic signed [pbb_pkg::ProdW-1:0] prod_px, prod_py, prod_vx, prod_vy;

  assign step_s = $signed({1'b0, ball_i.step});

  // truncating products, low fraction bits dropped
  always_comb begin
    prod_px = ball_i.vel_x * step_s;
    prod_py = ball_i.vel_y * step_s;
    prod_vx = grav_x_i * step_s;
    prod_vy = grav_y_i * step_s;
    delta_d.pos_x  = ball_i.pos_x;
    delta_d.pos_y  = ball_i.pos_y;
    delta_d.vel_x  = ball_i.vel_x;
    delta_d.vel_y  = ball_i.vel_y;
    delta_d.dpos_x = prod_px[pbb_pkg::ProdW-1:pbb_pkg::FracW];
    delta_d.dpos_y = prod_py[pbb_pkg::ProdW-1:pbb_pkg::FracW];
    delta_d.dvel_x = prod_vx[pbb_pkg::ProdW-1:pbb_pkg::FracW];
    delta_d.dvel_y = prod_vy[pbb_pkg::ProdW-1:pbb_pkg::FracW];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      delta_q <= delta_d;
    end
  end

  assign valid_o = valid_q;
  assign delta_o = delta_q;

endmodule

// ===== rtl/pbb_sum_stage.sv =====
`timescale 1ns / 1ps

module pbb_sum_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  pbb_pkg::delta_t  delta_i,
  output logic             valid_o,
  input  logic             ready_i,
  output pbb_pkg::result_t result_o
);

  logic             valid_q;
  pbb_pkg::result_t result_d, result_q;

  always_comb begin
    result_d.new_pos_x = pbb_pkg::sat_q(pbb_pkg::wide_t'(delta_i.pos_x)
                                        + pbb_pkg::wide_t'(delta_i.dpos_x));
    result_d.new_pos_y = pbb_pkg::sat_q(pbb_pkg::wide_t'(delta_i.pos_y)
                                        + pbb_pkg::wide_t'(delta_i.dpos_y));
    result_d.new_vel_x = pbb_pkg::sat_q(pbb_pkg::wide_t'(delta_i.vel_x)
                                        + pbb_pkg::wide_t'(delta_i.dvel_x));
    result_d.new_vel_y = pbb_pkg::sat_q(pbb_pkg::wide_t'(delta_i.vel_y)
                                        + pbb_pkg::wide_t'(delta_i.dvel_y));
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== rtl/particle_box_bounce_euler_step_core.sv =====
`timescale 1ns / 1ps

// Advances one ball by one explicit Euler step inside a box with reflecting walls.
// Four pipeline stages: low-wall checks (x and y side by side), high-wall checks,
// the four step products, then the saturating sums into the output register.
// A request is taken every cycle while the output side takes results; each
// request passes the low-wall, high-wall, product and sum registers in order,
// and a stall on the output holds every stage in place. Walls and gravity sit
// on the APB port and should only be written while no request is in flight.
module particle_box_bounce_euler_step_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pbb_pkg::AddrW-1:0]  paddr,
  input  logic [pbb_pkg::DataW-1:0]  pwdata,
  output logic [pbb_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [31:0]         pos_x_i,
  input  logic signed [31:0]         pos_y_i,
  input  logic signed [31:0]         vel_x_i,
  input  logic signed [31:0]         vel_y_i,
  input  logic [30:0]                ball_radius_i,
  input  logic [23:0]                time_step_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [31:0]         new_pos_x_o,
  output logic signed [31:0]         new_pos_y_o,
  output logic signed [31:0]         new_vel_x_o,
  output logic signed [31:0]         new_vel_y_o
);

  pbb_pkg::cfg_t     cfg_q;
  pbb_pkg::reg_idx_e reg_idx;
  pbb_pkg::ball_t    ball_in, ball_lo, ball_hi;
  pbb_pkg::delta_t   delta;
  pbb_pkg::result_t  result;
  logic              lo_valid, lo_ready, hi_valid, hi_ready, mul_valid, mul_ready;

  assign reg_idx = pbb_pkg::reg_idx_e'(paddr[pbb_pkg::AddrW-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_x  <= pbb_pkg::WallLowReset;
      cfg_q.high_x <= pbb_pkg::WallHighReset;
      cfg_q.low_y  <= pbb_pkg::WallLowReset;
      cfg_q.high_y <= pbb_pkg::WallHighReset;
      cfg_q.grav_x <= pbb_pkg::GravityReset;
      cfg_q.grav_y <= pbb_pkg::GravityReset;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        pbb_pkg::RegWallLowX:  cfg_q.low_x  <= pwdata;
        pbb_pkg::RegWallHighX: cfg_q.high_x <= pwdata;
        pbb_pkg::RegWallLowY:  cfg_q.low_y  <= pwdata;
        pbb_pkg::RegWallHighY: cfg_q.high_y <= pwdata;
        pbb_pkg::RegGravityX:  cfg_q.grav_x <= pwdata;
        pbb_pkg::RegGravityY:  cfg_q.grav_y <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pbb_pkg::RegWallLowX:  prdata = cfg_q.low_x;
      pbb_pkg::RegWallHighX: prdata = cfg_q.high_x;
      pbb_pkg::RegWallLowY:  prdata = cfg_q.low_y;
      pbb_pkg::RegWallHighY: prdata = cfg_q.high_y;
      pbb_pkg::RegGravityX:  prdata = cfg_q.grav_x;
      pbb_pkg::RegGravityY:  prdata = cfg_q.grav_y;
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    ball_in.pos_x  = pos_x_i;
    ball_in.pos_y  = pos_y_i;
    ball_in.vel_x  = vel_x_i;
    ball_in.vel_y  = vel_y_i;
    ball_in.radius = ball_radius_i;
    ball_in.step   = time_step_i;
  end

  pbb_wall_stage u_wall_lo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .check_high_i (1'b0),
    .wall_x_i     (cfg_q.low_x),
    .wall_y_i     (cfg_q.low_y),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .ball_i       (ball_in),
    .valid_o      (lo_valid),
    .ready_i      (lo_ready),
    .ball_o       (ball_lo)
  );

  pbb_wall_stage u_wall_hi (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .check_high_i (1'b1),
    .wall_x_i     (cfg_q.high_x),
    .wall_y_i     (cfg_q.high_y),
    .valid_i      (lo_valid),
    .ready_o      (lo_ready),
    .ball_i       (ball_lo),
    .valid_o      (hi_valid),
    .ready_i      (hi_ready),
    .ball_o       (ball_hi)
  );

  pbb_mul_stage u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .grav_x_i (cfg_q.grav_x),
    .grav_y_i (cfg_q.grav_y),
    .valid_i  (hi_valid),
    .ready_o  (hi_ready),
    .ball_i   (ball_hi),
    .valid_o  (mul_valid),
    .ready_i  (mul_ready),
    .delta_o  (delta)
  );

  pbb_sum_stage u_sum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mul_valid),
    .ready_o  (mul_ready),
    .delta_i  (delta),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (result)
  );

  assign new_pos_x_o = result.new_pos_x;
  assign new_pos_y_o = result.new_pos_y;
  assign new_vel_x_o = result.new_vel_x;
  assign new_vel_y_o = result.new_vel_y;

endmodule

// ===== rtl/pbb_checker.sv =====
`timescale 1ns / 1ps

module pbb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] new_pos_x_o,
  input logic signed [31:0] new_pos_y_o,
  input logic signed [31:0] new_vel_x_o,
  input logic signed [31:0] new_vel_y_o
);

  // an idle or draining output never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready_i || !out_valid_o) |-> in_ready_o)
    else $error("input stalled while output side can move");

  // an accepted request passes all four stages while the output keeps taking
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_o)
    else $error("request did not reach the output in four cycles");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(new_pos_x_o)
    && $stable(new_pos_y_o) && $stable(new_vel_x_o) && $stable(new_vel_y_o)))
    else $error("stalled result changed");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result withdrawn without being taken");

endmodule

bind particle_box_bounce_euler_step_core pbb_checker u_pbb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .new_pos_x_o (new_pos_x_o),
  .new_pos_y_o (new_pos_y_o),
  .new_vel_x_o (new_vel_x_o),
  .new_vel_y_o (new_vel_y_o)
);
